// ===== src/itrd_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function of the radix digit converter.
package itrd_pkg;

	// Bits of the input value taken into the conversion
	localparam int VALUE_WIDTH = 32;
	// Input port width, fixed by the item format
	localparam int IN_W = 32;
	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W = 7;
	localparam int CFG_W = 6;
	// Digit store depth equals the most digits a value can have (radix 2)
	localparam int STORE_DEPTH = VALUE_WIDTH;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int STEP_W = $clog2(VALUE_WIDTH);

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_RADIX      = 1'b0,
		REG_UPPER_CASE = 1'b1
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_LOAD,
		ST_HOLD
	} itrd_state_t;

	// Request to the shared divider
	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [RADIX_W-1:0]     divisor;
	} div_req_t;

	// Result of the shared divider
	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [DIGIT_W-1:0]     remainder;
	} div_rsp_t;

	// Map a digit to its ASCII code; letters above nine in either case
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [DIGIT_W-1:0] dc;
		logic [CHAR_W-1:0]  res;
		dc = (d > DIGIT_W'(35)) ? DIGIT_W'(35) : d;
		if (dc < DIGIT_W'(10)) begin
			res = CHAR_W'(dc) + CHAR_W'(48);
		end else if (upper) begin
			res = CHAR_W'(dc) + CHAR_W'(55);
		end else begin
			res = CHAR_W'(dc) + CHAR_W'(87);
		end
		return res;
	endfunction

endpackage

// ===== src/itrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/itrd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
module itrd_div import itrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     dsr_q;

	logic [DIGIT_W:0]       trial;
	logic [DIGIT_W:0]       diff;
	logic                   ge;
	logic [DIGIT_W-1:0]     rem_next;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
		diff = trial - {1'b0, dsr_q};
		ge = (trial >= {1'b0, dsr_q});
		rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	// Control: busy over the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(VALUE_WIDTH - 1);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== src/integer_to_radix_digits_unit.sv =====
// Top level: converts an unsigned value to ASCII digits in a configured radix.
//
// Input channel (in_valid / in_stall / value) takes one unsigned value per item.
// Output channel (out_valid / out_stall / character / last_digit) gives one
// ASCII digit per item, most significant first; last_digit marks the final one.
// A zero value gives the single character '0'.
// Configuration: cfg_write with cfg_index selects radix (index 0, reset 10,
// 0 and 1 act as 2, above 36 acts as 36) or upper_case (index 1, reset 0).
// Write configuration only while in_stall is low.
// Operation: the bit-serial divider finds the digits least significant first
// and writes them to a digit store. The store is then read back in reverse,
// passing through the read, load and hold states for each digit; the hold
// state waits while out_stall is high.
// in_stall is high from acceptance until the last digit has been taken.
// A stalled output holds its digit; the block waits without losing anything.
// Reset returns the sequencer to idle, clears the output valid and restores
// the configuration reset values; the digit store needs no clearing.
module integer_to_radix_digits_unit import itrd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IN_W-1:0]   value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] character,
	output logic              last_digit,
	input  logic              cfg_write,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	itrd_state_t        state_q, state_d;
	logic [RADIX_W-1:0] radix_q;
	logic               upper_q;
	logic [RADIX_W-1:0] eff_radix;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic               ram_we;
	logic [DIGIT_W-1:0] ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			upper_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RADIX: begin
					radix_q <= cfg_data[RADIX_W-1:0];
				end
				REG_UPPER_CASE: begin
					upper_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the radix into the legal range
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	// Sequencer: next state, divider requests, store writes
	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		ram_we = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = div_rsp.quotient;
		div_req.divisor = eff_radix;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				div_req.dividend = VALUE_WIDTH'(value);
				if (in_valid) begin
					div_req.start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					ram_we = 1'b1;
					if (div_rsp.quotient != '0) begin
						div_req.start = 1'b1;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_stall) begin
					state_d = last_q ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, store indexes and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				wr_idx_q <= '0;
			end
			if (state_q == ST_DIV && div_rsp.done) begin
				wr_idx_q <= wr_idx_q + IDX_W'(1);
				rd_idx_q <= wr_idx_q;
			end
			if (state_q == ST_LOAD) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_HOLD && !out_stall) begin
				out_valid_q <= 1'b0;
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			end
		end
	end

	// Output payload, loaded from the store read data
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			char_q <= digit_to_ascii(ram_rdata, upper_q);
			last_q <= (rd_idx_q == '0);
		end
	end

	itrd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	itrd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (div_rsp.remainder),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_digit = last_q;

	// No new item is taken while a digit is still pending
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("item accepted while a digit is pending");

	// Divider finishes only while the sequencer is dividing
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside the divide phase");

	// A digit is offered only in the hold state
	a_valid_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_HOLD))
		else $error("output valid outside the hold state");

	// Taking the final digit frees the input channel
	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_digit) |=> !in_stall)
		else $error("input still stalled after the final digit");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the radix digit converter: directed and random values, per-digit checks.
`timescale 1ns / 1ps

module tb_top;
	import itrd_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	// Idle stretch after each drained batch, before the next register write
	localparam int DRAIN_CYCLES = 4 * (VALUE_WIDTH + 4);
	localparam int RANDOM_SETTINGS = 12;
	localparam int VALUES_PER_SETTING = 25;
	localparam logic [IN_W-1:0] VALUE_MASK = {IN_W{1'b1}} >> (IN_W - VALUE_WIDTH);

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} digit_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [IN_W-1:0]   value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CHAR_W-1:0] character;
	logic              last_digit;
	logic              cfg_write = 1'b0;
	logic [0:0]        cfg_index = REG_RADIX;
	logic [CFG_W-1:0]  cfg_data = '0;

	// Mirror of the configuration registers as last written
	logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
	logic               cfg_upper = 1'b0;

	logic [IN_W-1:0] value_queue[$];
	digit_t          expected_digits[$];

	logic [RADIX_W-1:0] extreme_radix[6] = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};

	int unsigned cycle_count = 0;
	int unsigned err_count = 0;
	int unsigned values_sent = 0;
	int unsigned digits_checked = 0;
	int unsigned settings_count = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	integer_to_radix_digits_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.last_digit (last_digit),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clamp the radix register into the usable range 2..36
	function automatic int unsigned eff_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) return 2;
		if (r > RADIX_MAX) return 36;
		return int'(r);
	endfunction

	// ASCII for one digit value under the current letter case
	function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] c;
		logic [7:0] dd;
		dd = (d > 35) ? 8'd35 : 8'(d);
		if (dd < 8'd10) begin
			c = "0" + dd;
		end else if (cfg_upper) begin
			c = "A" + (dd - 8'd10);
		end else begin
			c = "a" + (dd - 8'd10);
		end
		return c[CHAR_W-1:0];
	endfunction

	// Divide down to remainders, then queue the digits most significant first
	function automatic void predict_digits(input logic [IN_W-1:0] v);
		logic [IN_W-1:0]    q;
		logic [IN_W-1:0]    base;
		logic [DIGIT_W-1:0] rems[$];
		digit_t             d;
		q = v & VALUE_MASK;
		base = IN_W'(eff_radix(cfg_radix));
		if (q == '0) rems.push_back('0);
		while (q != '0 && rems.size() < VALUE_WIDTH) begin
			rems.push_back(DIGIT_W'(q % base));
			q = q / base;
		end
		for (int i = rems.size() - 1; i >= 0; i--) begin
			d.code = to_char(rems[i]);
			d.last = (i == 0);
			expected_digits.push_back(d);
		end
	endfunction

	// Wait cycles for one item; occasionally switch between idling and back-to-back stretches
	function automatic int unsigned draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// Value mix: zero, all ones, powers of the radix and the values just below them, short and wide randoms
	function automatic logic [IN_W-1:0] value_for(input int unsigned b);
		longint unsigned p;
		int unsigned     k;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: begin
				p = 1;
				k = $urandom_range(1, VALUE_WIDTH);
				repeat (k) if (p * b < (64'd1 << VALUE_WIDTH)) p = p * b;
				return IN_W'(p - $urandom_range(0, 1));
			end
			4, 5, 6: return IN_W'($urandom) >> $urandom_range(0, IN_W - 1);
			default: return IN_W'($urandom_range(0, 999));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	// Compare one digit against the oldest expectation
	task automatic check_digit(input logic [CHAR_W-1:0] c, input logic l);
		digit_t e;
		if (expected_digits.size() == 0) begin
			report_mismatch($sformatf("digit 0x%02h last=%0b with nothing expected", c, l));
			return;
		end
		e = expected_digits.pop_front();
		if (c !== e.code)
			report_mismatch($sformatf("character 0x%02h, expected 0x%02h", c, e.code));
		if (l !== e.last)
			report_mismatch($sformatf("last_digit %0b, expected %0b (char 0x%02h)", l, e.last,
				e.code));
		digits_checked++;
	endtask

	// Write both registers and update the mirror
	task automatic load_setting(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] u);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_RADIX;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_UPPER_CASE;
		cfg_data <= u;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_radix = r;
		cfg_upper = u[0];
		settings_count++;
	endtask

	// Hold until every item is taken and every digit has come out, then let the block settle
	task automatic wait_drained();
		do @(negedge clk);
		while (value_queue.size() != 0 || in_valid || in_stall !== 1'b0
				|| expected_digits.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Drive values: predict on acceptance, hold while stalled, idle between items
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_digits(value);
				values_sent++;
				gap_left = draw_wait(tx_calm);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (value_queue.size() > 0) begin
					in_valid <= 1'b1;
					value <= value_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take digits, check each one, and stall the output at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (out_valid && !out_stall) begin
			check_digit(character, last_digit);
			hold_left = draw_wait(rx_calm);
			out_stall <= (hold_left != 0);
		end else if (out_stall) begin
			if (hold_left <= 1) out_stall <= 1'b0;
			if (hold_left > 0) hold_left--;
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d digits still expected", cycle_count,
				expected_digits.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [RADIX_W-1:0] r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// Reset settings: decimal, lower case; zero, widest value, one- and two-digit edges
		value_queue.push_back('0);
		value_queue.push_back('1);
		value_queue.push_back(IN_W'(10));
		value_queue.push_back(IN_W'(9));
		wait_drained();

		// Radix below two acts as binary; all ones gives the longest digit run
		load_setting(6'd0, 6'd0);
		value_queue.push_back('1);
		value_queue.push_back(IN_W'(1));
		wait_drained();
		load_setting(6'd1, 6'd62);
		value_queue.push_back(IN_W'(32'h8000_0000));
		value_queue.push_back(IN_W'(32'h5555_5555));
		wait_drained();
		load_setting(6'd2, 6'd0);
		value_queue.push_back(IN_W'(32'hAAAA_AAAA));
		wait_drained();

		// Base 36 in both letter cases
		load_setting(6'd36, 6'd0);
		value_queue.push_back(IN_W'(35));
		value_queue.push_back(IN_W'(36 * 36 - 1));
		value_queue.push_back('1);
		wait_drained();
		load_setting(6'd36, 6'd1);
		value_queue.push_back(IN_W'(35));
		value_queue.push_back('1);
		wait_drained();

		// Radix above thirty-six acts as base 36
		load_setting(6'd63, 6'd1);
		value_queue.push_back('1);
		value_queue.push_back('0);
		wait_drained();
		load_setting(6'd37, 6'd0);
		value_queue.push_back(IN_W'(36 * 36 - 1));
		wait_drained();

		// Hexadecimal upper case
		load_setting(6'd16, 6'd1);
		value_queue.push_back(IN_W'(32'hDEAD_BEEF));
		value_queue.push_back(IN_W'(32'h00AB_CDEF));
		wait_drained();

		// Random settings, each with a batch of random values
		for (int p = 0; p < RANDOM_SETTINGS; p++) begin
			if ($urandom_range(0, 3) == 0) r = extreme_radix[$urandom_range(0, 5)];
			else r = RADIX_W'($urandom_range(2, 36));
			load_setting(r, CFG_W'($urandom_range(0, 63)));
			for (int i = 0; i < VALUES_PER_SETTING; i++)
				value_queue.push_back(value_for(eff_radix(r)));
			wait_drained();
		end

		$display("Converted %0d values into %0d checked digits over %0d register settings",
			values_sent, digits_checked, settings_count);
		$display("Radix 0, 1, 37 and 63 clamps, both letter cases, zero and all-ones values run");
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", err_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
